@@ hw/rtl/tica_pkg.sv @@
// types, codes and helpers shared by the typed integer alu
package tica_pkg;

  typedef enum logic [3:0] {
    OP_MUL = 4'd0,
    OP_DIV = 4'd1,
    OP_MOD = 4'd2,
    OP_SHL = 4'd3,
    OP_SHR = 4'd4,
    OP_ADD = 4'd5,
    OP_SUB = 4'd6,
    OP_XOR = 4'd7,
    OP_AND = 4'd8,
    OP_OR  = 4'd9,
    OP_NEG = 4'd10,
    OP_POS = 4'd11
  } op_e;

  typedef enum logic [3:0] {
    TY_I8   = 4'd0,
    TY_U8   = 4'd1,
    TY_I16  = 4'd2,
    TY_U16  = 4'd3,
    TY_I32  = 4'd4,
    TY_U32  = 4'd5,
    TY_I64  = 4'd6,
    TY_U64  = 4'd7,
    TY_INT  = 4'd8,
    TY_UINT = 4'd9
  } type_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_DIVZERO     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SIGNED_ALIAS   = 2'd0,
    CFG_UNSIGNED_ALIAS = 2'd1
  } cfg_idx_e;

  localparam int unsigned DivStages = 64;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  type_code;
    logic [63:0] left_value;
    logic [63:0] right_value;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [1:0]  status;
  } out_rsp_t;

  // control that travels with every request
  typedef struct packed {
    logic [3:0] op;
    logic [1:0] wc;
    logic       sgn;
    logic [1:0] st;
    logic       na;
    logic       nb;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] a;
    logic [63:0] b;
  } s1_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] res;
    logic [63:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } s2_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [63:0] mb;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] res;
  } dv_t;

  function automatic logic [63:0] wmask(input logic [1:0] wc);
    logic [63:0] m;
    case (wc)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [63:0] v, input logic [1:0] wc);
    logic t;
    case (wc)
      2'd0:    t = v[7];
      2'd1:    t = v[15];
      2'd2:    t = v[31];
      default: t = v[63];
    endcase
    return t;
  endfunction

  // truncate to width, then sign or zero extend
  function automatic logic [63:0] fit(input logic [63:0] v, input logic [1:0] wc,
                                      input logic sgn);
    logic [63:0] m;
    m = wmask(wc);
    return (sgn && top_bit(v, wc)) ? (v | ~m) : (v & m);
  endfunction

endpackage

@@ hw/rtl/typed_integer_constant_alu_core.sv @@
// typed integer alu: decode, execute, pipelined divider and result fixup
//
//  channel | signals                              | moves
//  in      | in_valid_i in_ready_o in_req_i       | op, type code, two operands
//  out     | out_valid_o out_ready_i out_rsp_o    | result and status
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | alias widths
//
// every request passes from acceptance to out_valid_o through decode, execute,
// multiply sum, 64 restoring divider stages of one quotient bit each, output.
// one request per cycle is accepted unless the output stalls; all stages advance together and hold while
// the output register is full and not taken, so a stall drops or repeats nothing.
// reset clears all valid bits and sets both alias widths to 32 bits.
module typed_integer_constant_alu_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tica_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tica_pkg::out_rsp_t out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [1:0]         cfg_data_i
);
  import tica_pkg::*;

  logic [1:0] sa_q, ua_q;
  logic       adv;

  s1_t        s1_d, s1_q;
  logic       s1_v_q;
  s2_t        s2_d, s2_q;
  logic       s2_v_q;
  dv_t        dv_q [DivStages+1];
  dv_t        dv_d [DivStages+1];
  logic       dv_v_q [DivStages+1];
  out_rsp_t   out_d, out_q;
  logic       out_v_q;

  assign adv         = !out_v_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= 2'd2;
      ua_q <= 2'd2;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SIGNED_ALIAS) sa_q <= cfg_data_i;
      else if (cfg_index_i == CFG_UNSIGNED_ALIAS) ua_q <= cfg_data_i;
    end
  end

  // decode type and truncate operands
  always_comb begin
    logic [63:0] m;
    s1_d = '0;
    s1_d.ctl.op = in_req_i.op;
    s1_d.ctl.st = ST_OK;
    case (in_req_i.type_code) inside
      TY_I8, TY_U8, TY_I16, TY_U16, TY_I32, TY_U32, TY_I64, TY_U64: begin
        s1_d.ctl.wc  = in_req_i.type_code[2:1];
        s1_d.ctl.sgn = ~in_req_i.type_code[0];
      end
      TY_INT: begin
        s1_d.ctl.wc  = sa_q;
        s1_d.ctl.sgn = 1'b1;
      end
      TY_UINT: begin
        s1_d.ctl.wc  = ua_q;
        s1_d.ctl.sgn = 1'b0;
      end
      default: s1_d.ctl.st = ST_UNSUPPORTED;
    endcase
    if (in_req_i.op > OP_POS) s1_d.ctl.st = ST_UNSUPPORTED;
    m = wmask(s1_d.ctl.wc);
    s1_d.a = in_req_i.left_value & m;
    s1_d.b = in_req_i.right_value & m;
    s1_d.ctl.na = s1_d.ctl.sgn && top_bit(s1_d.a, s1_d.ctl.wc);
    s1_d.ctl.nb = s1_d.ctl.sgn && top_bit(s1_d.b, s1_d.ctl.wc);
    if ((in_req_i.op == OP_DIV || in_req_i.op == OP_MOD) && s1_d.b == '0
        && s1_d.ctl.st == ST_OK) begin
      s1_d.ctl.st = ST_DIVZERO;
    end
  end

  // simple ops, operand magnitudes and multiply partial products
  always_comb begin
    logic [63:0] m, ax, wid;
    logic        big;
    logic [5:0]  sh;
    m   = wmask(s1_q.ctl.wc);
    wid = 64'd8 << s1_q.ctl.wc;
    big = s1_q.b >= wid;
    sh  = s1_q.b[5:0];
    ax  = fit(s1_q.a, s1_q.ctl.wc, s1_q.ctl.sgn);
    s2_d.ctl = s1_q.ctl;
    s2_d.ma  = s1_q.ctl.na ? ((64'd0 - s1_q.a) & m) : s1_q.a;
    s2_d.mb  = s1_q.ctl.nb ? ((64'd0 - s1_q.b) & m) : s1_q.b;
    s2_d.p0  = {32'd0, s1_q.a[31:0]} * {32'd0, s1_q.b[31:0]};
    s2_d.p1  = 32'(s1_q.a[31:0] * s1_q.b[63:32]);
    s2_d.p2  = 32'(s1_q.a[63:32] * s1_q.b[31:0]);
    case (s1_q.ctl.op)
      OP_SHL:  s2_d.res = big ? 64'd0 : (s1_q.a << sh);
      OP_SHR: begin
        if (big) s2_d.res = s1_q.ctl.na ? m : 64'd0;
        else if (s1_q.ctl.sgn) s2_d.res = 64'($signed(ax) >>> sh);
        else s2_d.res = s1_q.a >> sh;
      end
      OP_ADD:  s2_d.res = s1_q.a + s1_q.b;
      OP_SUB:  s2_d.res = s1_q.a - s1_q.b;
      OP_XOR:  s2_d.res = s1_q.a ^ s1_q.b;
      OP_AND:  s2_d.res = s1_q.a & s1_q.b;
      OP_OR:   s2_d.res = s1_q.a | s1_q.b;
      OP_NEG:  s2_d.res = 64'd0 - s1_q.a;
      OP_POS:  s2_d.res = s1_q.a;
      default: s2_d.res = 64'd0;
    endcase
  end

  // multiply sum and divider setup
  always_comb begin
    logic [31:0] hi;
    hi = s2_q.p1 + s2_q.p2;
    dv_d[0].ctl = s2_q.ctl;
    dv_d[0].mb  = s2_q.mb;
    dv_d[0].rem = '0;
    dv_d[0].quo = s2_q.ma;
    dv_d[0].res = (s2_q.ctl.op == OP_MUL) ? (s2_q.p0 + {hi, 32'd0}) : s2_q.res;
  end

  // one restoring divide step per stage
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_comb begin
      logic [64:0] t;
      logic        ge;
      t  = {dv_q[k-1].rem, dv_q[k-1].quo[63]};
      ge = t >= {1'b0, dv_q[k-1].mb};
      dv_d[k]     = dv_q[k-1];
      dv_d[k].rem = ge ? 64'(t - {1'b0, dv_q[k-1].mb}) : t[63:0];
      dv_d[k].quo = {dv_q[k-1].quo[62:0], ge};
    end
  end

  // sign fixup, selection and extension
  always_comb begin
    dv_t         l;
    logic [63:0] r;
    l = dv_q[DivStages];
    case (l.ctl.op)
      OP_DIV:  r = (l.ctl.na != l.ctl.nb) ? (64'd0 - l.quo) : l.quo;
      OP_MOD:  r = l.ctl.na ? (64'd0 - l.rem) : l.rem;
      default: r = l.res;
    endcase
    if (l.ctl.st != ST_OK) r = '0;
    out_d.result_value = fit(r, l.ctl.wc, l.ctl.sgn);
    out_d.status       = l.ctl.st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i <= DivStages; i++) dv_v_q[i] <= 1'b0;
    end else if (adv) begin
      s1_v_q    <= in_valid_i;
      s2_v_q    <= s1_v_q;
      dv_v_q[0] <= s2_v_q;
      for (int i = 1; i <= DivStages; i++) dv_v_q[i] <= dv_v_q[i-1];
      out_v_q   <= dv_v_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      out_q <= out_d;
      for (int i = 0; i <= DivStages; i++) dv_q[i] <= dv_d[i];
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.result_value == '0)
    else $error("error status with nonzero result");

  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[DivStages] && dv_q[DivStages].ctl.st == ST_OK
    && dv_q[DivStages].ctl.op == OP_MOD |-> dv_q[DivStages].rem < dv_q[DivStages].mb)
    else $error("remainder not below divisor");

  a_divzero_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_q.ctl.st == ST_DIVZERO |-> s1_q.b == '0
    && (s1_q.ctl.op == OP_DIV || s1_q.ctl.op == OP_MOD))
    else $error("divide by zero flagged on wrong request");

endmodule

@@ test/tb_top.sv @@
// testbench for the typed integer alu: random and directed requests checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import tica_pkg::*;

  class alu_scoreboard;
    out_rsp_t pending_q[$];
    int       errors;
    logic [1:0] int_wc;
    logic [1:0] uint_wc;

    function void set_alias(input logic [1:0] idx, input logic [1:0] val);
      if (idx == CFG_SIGNED_ALIAS) int_wc = val;
      else if (idx == CFG_UNSIGNED_ALIAS) uint_wc = val;
    endfunction

    // expected result of one request
    function out_rsp_t compute(input in_req_t rq);
      out_rsp_t   rs;
      int         w;
      bit         sgn;
      logic [63:0] m, a, b, r, top, ma, mb;
      bit         na, nb;
      rs = '0;
      if (rq.type_code <= TY_U64) begin
        w = 8 << rq.type_code[2:1];
        sgn = !rq.type_code[0];
      end else if (rq.type_code == TY_INT) begin
        w = 8 << int_wc;
        sgn = 1;
      end else if (rq.type_code == TY_UINT) begin
        w = 8 << uint_wc;
        sgn = 0;
      end else begin
        rs.status = ST_UNSUPPORTED;
        return rs;
      end
      m = (w == 64) ? '1 : ((64'd1 << w) - 1);
      a = rq.left_value & m;
      b = rq.right_value & m;
      top = 64'd1 << (w - 1);
      na = sgn && (a & top) != 0;
      nb = sgn && (b & top) != 0;
      r = '0;
      rs.status = ST_OK;
      case (rq.op)
        OP_MUL: r = a * b;
        OP_DIV, OP_MOD: begin
          if (b == 0) rs.status = ST_DIVZERO;
          else begin
            ma = na ? ((-a) & m) : a;
            mb = nb ? ((-b) & m) : b;
            if (rq.op == OP_DIV) begin
              r = ma / mb;
              if (na != nb) r = -r;
            end else begin
              r = ma % mb;
              if (na) r = -r;
            end
          end
        end
        OP_SHL: r = (b >= w) ? 64'd0 : (a << b);
        OP_SHR: begin
          if (b >= w) r = na ? m : 64'd0;
          else begin
            r = a >> b;
            if (na && b > 0) r |= m & ~(m >> b);
          end
        end
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_XOR: r = a ^ b;
        OP_AND: r = a & b;
        OP_OR:  r = a | b;
        OP_NEG: r = -a;
        OP_POS: r = a;
        default: rs.status = ST_UNSUPPORTED;
      endcase
      if (rs.status != ST_OK) r = '0;
      r &= m;
      if (sgn && w < 64 && (r & top) != 0) r |= ~m;
      rs.result_value = r;
      return rs;
    endfunction

    function void note_request(input in_req_t rq);
      pending_q.push_back(compute(rq));
    endfunction

    function void check_result(input out_rsp_t got);
      out_rsp_t exp_rsp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_rsp = pending_q.pop_front();
      if (got.result_value !== exp_rsp.result_value) begin
        $display("%0t: result_value expected %h actual %h", $time,
                 exp_rsp.result_value, got.result_value);
        errors++;
      end
      if (got.status !== exp_rsp.status) begin
        $display("%0t: status expected %0d actual %0d", $time,
                 exp_rsp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     in_valid_i = 0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 0;
  out_rsp_t out_rsp_o;
  logic     cfg_valid_i = 0;
  logic     cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [1:0] cfg_data_i = '0;

  alu_scoreboard sb;
  bit quiet_mode;
  bit hold_off;

  typed_integer_constant_alu_core u_dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // accept results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (150) @(negedge clk_i);
        hold_off = 0;
        out_ready_i <= 1;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 4);
        out_ready_i <= 0;
        repeat (n) @(negedge clk_i);
        out_ready_i <= 1;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  // valid stays high between back-to-back requests; it drops only for an idle gap or in drain
  task automatic send_request(input in_req_t rq);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_req_i <= rq;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(rq);
    @(negedge clk_i);
  endtask

  task automatic write_alias(input logic [1:0] idx, input logic [1:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_alias(idx, val);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = v & 64'hff;
      3: v = 64'd1 << $urandom_range(0, 63);
      4: v = $urandom_range(0, 70);
      5: v = v | 64'h80 | (64'd1 << 15) | (64'd1 << 31) | (64'd1 << 63);
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_req_t rand_request();
    in_req_t rq;
    rq.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
    rq.type_code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
    rq.left_value = rand_operand();
    rq.right_value = rand_operand();
    return rq;
  endfunction

  initial begin
    in_req_t rq;
    sb = new();
    sb.int_wc = 2;
    sb.uint_wc = 2;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: every op on the extremes, minimum over -1, shifts and a zero divisor
    for (int o = 0; o < 13; o++) begin
      rq.op = 4'(o);
      rq.type_code = TY_I8;
      rq.left_value = 64'h80;
      rq.right_value = '1;
      send_request(rq);
    end
    rq.op = OP_MOD; rq.type_code = TY_I64; rq.left_value = 64'h8000_0000_0000_0000;
    rq.right_value = '1; send_request(rq);
    rq.op = OP_DIV; rq.type_code = TY_U32; rq.right_value = '0; send_request(rq);
    rq.op = OP_SHR; rq.type_code = TY_I16; rq.left_value = 64'h8000;
    rq.right_value = 64'd16; send_request(rq);
    rq.right_value = 64'd3; send_request(rq);
    rq.op = OP_SHL; rq.type_code = TY_U64; rq.left_value = '1;
    rq.right_value = 64'd64; send_request(rq);
    rq.op = OP_MUL; rq.type_code = 4'd15; send_request(rq);
    rq.op = OP_ADD; rq.type_code = TY_UINT; send_request(rq);
    rq.type_code = TY_INT; send_request(rq);

    // random phases across alias settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_alias(CFG_SIGNED_ALIAS, (ph == 0) ? 2'd0 : (ph == 1) ? 2'd3 : 2'($urandom));
      write_alias(CFG_UNSIGNED_ALIAS, (ph == 0) ? 2'd3 : (ph == 1) ? 2'd0 : 2'($urandom));
      cfg_valid_i <= 0;
      if (ph == 2) hold_off = 1;
      if (ph == 5) quiet_mode = 1;
      for (int i = 0; i < 300; i++) send_request(rand_request());
    end
    drain();
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
